// ===== design/assert_macros.svh =====
// Assertion macros used by the top-level design file.
// No dependencies; define NO_ASSERTIONS to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// The property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");
// If the antecedent holds, the consequent must hold in the same cycle.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_ALWAYS(label, clk, rst_n, expr)
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== design/bdg_pkg.sv =====
// Shared constants, tables and types of the base-10000 digit group converter.
// No dependencies.
package bdg_pkg;

    localparam int VALUE_BITS_DEF = 64;
    localparam int SCALE_W        = 5;
    localparam int MAX_SCALE      = 18;
    localparam int GROUP_W        = 14;
    localparam int GROUP_BASE     = 10000;
    localparam int HALF_BASE      = 5000;
    localparam int NUM_GROUPS     = 6;
    // The fraction is left aligned by at most a factor of 1000, ten bits.
    localparam int CORR_BITS      = 10;
    localparam int BITS_PER_STEP  = 8;
    localparam int QUEUE_DEPTH    = 2;

    // Powers of ten used to left align the fraction part.
    localparam logic [CORR_BITS-1:0] POW10 [4] = '{10'd1, 10'd10, 10'd100, 10'd1000};

    typedef struct packed {
        logic valid;
        logic full;
    } q_status_t;

    typedef struct packed {
        logic [GROUP_W-1:0] digit_group;
        logic               negative;
        logic signed [3:0]  weight;
        logic [2:0]         group_count;
        logic [2:0]         group_index;
        logic               last;
        logic               empty_res;
    } res_t;

endpackage

// ===== design/bdg_front.sv =====
// Front end: holds the scale register, accepts input words and prepares them.
// Depends on bdg_pkg; feeds bdg_queue.
module bdg_front #(
    parameter int VALUE_BITS = bdg_pkg::VALUE_BITS_DEF,
    localparam int XW = VALUE_BITS + bdg_pkg::CORR_BITS,
    localparam int QW = XW + 4
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write,
    input  logic [bdg_pkg::SCALE_W-1:0]       cfg_data,
    input  logic                              push,
    input  logic signed [VALUE_BITS-1:0]      value,
    output logic                              full,
    input  bdg_pkg::q_status_t                q_stat,
    output logic                              q_write,
    output logic [QW-1:0]                     q_wdata
);

    logic [bdg_pkg::SCALE_W-1:0] scale_reg;
    logic                        st_valid_reg;
    logic                        st_valid_next;
    logic [VALUE_BITS-1:0]       st_mag_reg;
    logic                        st_neg_reg;
    logic [2:0]                  st_nf_reg;
    logic [1:0]                  st_corr_reg;

    logic                        accept;
    logic [VALUE_BITS-1:0]       v;
    logic                        neg;
    logic [VALUE_BITS-1:0]       mag;
    logic [bdg_pkg::SCALE_W-1:0] s_clamp;
    logic [2:0]                  nf;
    logic [1:0]                  corr;
    logic [XW-1:0]               x_aligned;

    assign full    = st_valid_reg && q_stat.full;
    assign accept  = push && !full;
    assign q_write = st_valid_reg && !q_stat.full;

    // Sign and unsigned magnitude; the most negative value maps onto itself.
    assign v   = value;
    assign neg = v[VALUE_BITS-1];
    assign mag = neg ? ('0 - v) : v;

    // Fraction group count is ceil(scale/4); corr pads it to whole groups.
    assign s_clamp = (scale_reg > bdg_pkg::SCALE_W'(bdg_pkg::MAX_SCALE))
                   ? bdg_pkg::SCALE_W'(bdg_pkg::MAX_SCALE) : scale_reg;
    assign nf      = 3'((s_clamp + 5'd3) >> 2);
    assign corr    = 2'({nf, 2'b00} - s_clamp);

    assign x_aligned = XW'(st_mag_reg) * XW'(bdg_pkg::POW10[st_corr_reg]);
    assign q_wdata   = {x_aligned, st_nf_reg, st_neg_reg};

    always_comb
    begin
        st_valid_next = st_valid_reg;
        if (accept)
        begin
            st_valid_next = 1'b1;
        end
        else if (q_write)
        begin
            st_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg    <= '0;
            st_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                scale_reg <= cfg_data;
            end
            st_valid_reg <= st_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            st_mag_reg  <= mag;
            st_neg_reg  <= neg;
            st_nf_reg   <= nf;
            st_corr_reg <= corr;
        end
    end

endmodule

// ===== design/bdg_queue.sv =====
// Short register queue between the front end and the converter.
// Depends on bdg_pkg for the status struct.
module bdg_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = bdg_pkg::QUEUE_DEPTH,
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CW = $clog2(DEPTH + 1)
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               wr_en,
    input  logic [WIDTH-1:0]   wdata,
    input  logic               rd_en,
    output logic [WIDTH-1:0]   rdata,
    output bdg_pkg::q_status_t stat
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wptr_reg;
    logic [PW-1:0]    rptr_reg;
    logic [CW-1:0]    count_reg;
    logic [PW-1:0]    wptr_next;
    logic [PW-1:0]    rptr_next;
    logic [CW-1:0]    count_next;

    assign stat.full  = (count_reg == CW'(DEPTH));
    assign stat.valid = (count_reg != '0);
    assign rdata      = mem_reg[rptr_reg];

    always_comb
    begin
        wptr_next  = wptr_reg;
        rptr_next  = rptr_reg;
        count_next = count_reg;
        if (wr_en)
        begin
            wptr_next = (wptr_reg == PW'(DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
        end
        if (rd_en)
        begin
            rptr_next = (rptr_reg == PW'(DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
        end
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (rd_en && !wr_en)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wptr_reg] <= wdata;
        end
    end

endmodule

// ===== design/bdg_back.sv =====
// Back end: base-10000 conversion by a shift-and-adjust loop and result emission.
// Depends on bdg_pkg; reads words from bdg_queue.
module bdg_back #(
    parameter int VALUE_BITS = bdg_pkg::VALUE_BITS_DEF,
    localparam int XW = VALUE_BITS + bdg_pkg::CORR_BITS,
    localparam int QW = XW + 4
) (
    input  logic               clk,
    input  logic               rst_n,
    input  bdg_pkg::q_status_t q_stat,
    input  logic [QW-1:0]      q_rdata,
    output logic               q_read,
    input  logic               pop,
    output logic               res_valid,
    output bdg_pkg::res_t      res
);

    localparam int STEP  = bdg_pkg::BITS_PER_STEP;
    localparam int STEPS = (XW + STEP - 1) / STEP;
    localparam int CW    = STEPS * STEP;
    localparam int CNT_W = $clog2(STEPS);
    localparam int NG    = bdg_pkg::NUM_GROUPS;
    localparam int GW    = bdg_pkg::GROUP_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CONV,
        S_DONE
    } state_t;

    state_t           state_reg;
    state_t           state_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;

    logic [CW-1:0]    x_reg;
    logic [GW-1:0]    grp_reg [NG];
    logic [GW-1:0]    grp_conv [NG];
    logic [2:0]       nf_reg;
    logic             neg_reg;

    logic [GW-1:0]    e_grp_reg [NG];
    logic             e_neg_reg;
    logic [2:0]       e_ni_reg;
    logic [2:0]       e_n_reg;
    logic [2:0]       e_idx_reg;
    logic [2:0]       e_idx_next;
    logic             e_valid_reg;
    logic             e_valid_next;

    logic [2:0]       ni;
    logic [2:0]       n_total;
    logic             load_emit;
    logic             emit_pop;
    logic             e_last;
    logic             emit_free;
    logic [2:0]       e_ptr;

    logic             carry;
    logic             hi;
    logic [GW:0]      dbl;

    assign q_read    = (state_reg == S_IDLE) && q_stat.valid;
    assign emit_pop  = pop && e_valid_reg;
    assign e_last    = (e_n_reg == '0) || (e_idx_reg == e_n_reg - 3'd1);
    assign emit_free = !e_valid_reg || (emit_pop && e_last);
    assign load_emit = (state_reg == S_DONE) && emit_free;

    // Eight shift-and-adjust steps: each group doubles and takes the carry
    // from below; a group at or above half the base wraps and carries out.
    always_comb
    begin
        grp_conv = grp_reg;
        for (int b = 0; b < STEP; b++)
        begin
            carry = x_reg[CW-1-b];
            for (int j = 0; j < NG; j++)
            begin
                hi  = (grp_conv[j] >= GW'(bdg_pkg::HALF_BASE));
                dbl = {grp_conv[j], carry};
                grp_conv[j] = hi ? GW'(dbl - (GW+1)'(bdg_pkg::GROUP_BASE)) : dbl[GW-1:0];
                carry = hi;
            end
        end
    end

    // Integer groups run from the lowest one above the fraction up to the
    // highest nonzero group.
    always_comb
    begin
        ni = '0;
        for (int j = 0; j < NG; j++)
        begin
            if ((grp_reg[j] != '0) && (3'(j) >= nf_reg))
            begin
                ni = 3'(j) - nf_reg + 3'd1;
            end
        end
        n_total = ni + nf_reg;
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (q_stat.valid)
                begin
                    state_next = S_CONV;
                    cnt_next   = CNT_W'(STEPS - 1);
                end
            end
            S_CONV:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            S_DONE:
            begin
                if (emit_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        e_valid_next = e_valid_reg;
        e_idx_next   = e_idx_reg;
        if (load_emit)
        begin
            e_valid_next = 1'b1;
            e_idx_next   = '0;
        end
        else if (emit_pop)
        begin
            if (e_last)
            begin
                e_valid_next = 1'b0;
            end
            else
            begin
                e_idx_next = e_idx_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            cnt_reg     <= '0;
            e_valid_reg <= 1'b0;
            e_idx_reg   <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            e_valid_reg <= e_valid_next;
            e_idx_reg   <= e_idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_read)
        begin
            x_reg   <= CW'(q_rdata[QW-1:4]);
            nf_reg  <= q_rdata[3:1];
            neg_reg <= q_rdata[0];
            grp_reg <= '{default: '0};
        end
        else if (state_reg == S_CONV)
        begin
            x_reg   <= x_reg << STEP;
            grp_reg <= grp_conv;
        end
        if (load_emit)
        begin
            e_grp_reg <= grp_reg;
            e_neg_reg <= neg_reg;
            e_ni_reg  <= ni;
            e_n_reg   <= n_total;
        end
    end

    // Groups sit least significant first; the run is read from the top down.
    assign e_ptr = e_n_reg - 3'd1 - e_idx_reg;

    always_comb
    begin
        res.digit_group = (e_n_reg == '0) ? '0 : e_grp_reg[e_ptr];
        res.negative    = e_neg_reg;
        res.weight      = {1'b0, e_ni_reg} - 4'sd1;
        res.group_count = e_n_reg;
        res.group_index = e_idx_reg;
        res.last        = e_last;
        res.empty_res   = (e_n_reg == '0);
    end

    assign res_valid = e_valid_reg;

endmodule

// ===== design/binary_decimal_to_base10000_groups.sv =====
// Top level of the scaled decimal to base-10000 digit group converter.
// Depends on bdg_pkg, bdg_front, bdg_queue, bdg_back and assert_macros.svh.
//
//   channel   direction  handshake           payload
//   config    in         cfg_write           cfg_data (scale, 5 bits)
//   input     in         push / full         value (VALUE_BITS bits, signed)
//   result    out        empty / pop         digit_group, negative, weight,
//                                            group_count, group_index, last,
//                                            empty_res
//
// The shift-and-adjust loop in bdg_back converts each word, taking eight bits of
// the aligned magnitude per cycle. While pop is held, results leave the output
// register one per cycle as the next word converts.
// Reset clears the scale register to 0 and empties the queue and output
// register; no clearing pass is needed.
// A stalled result side fills the two-entry queue and the front stage, and
// full then rises; the input side never blocks results.
`include "assert_macros.svh"

module binary_decimal_to_base10000_groups #(
    parameter int VALUE_BITS = bdg_pkg::VALUE_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write,
    input  logic [bdg_pkg::SCALE_W-1:0]      cfg_data,
    input  logic                             push,
    input  logic signed [VALUE_BITS-1:0]     value,
    output logic                             full,
    output logic                             empty,
    input  logic                             pop,
    output logic [bdg_pkg::GROUP_W-1:0]      digit_group,
    output logic                             negative,
    output logic signed [3:0]                weight,
    output logic [2:0]                       group_count,
    output logic [2:0]                       group_index,
    output logic                             last,
    output logic                             empty_res
);

    // Queue word: aligned magnitude, fraction group count and sign.
    localparam int QW = VALUE_BITS + bdg_pkg::CORR_BITS + 4;

    bdg_pkg::q_status_t q_stat;
    logic               q_write;
    logic [QW-1:0]      q_wdata;
    logic               q_read;
    logic [QW-1:0]      q_rdata;
    logic               res_valid;
    bdg_pkg::res_t      res;

    // The front end splits off the sign, clamps the scale and multiplies the
    // magnitude so that the fraction fills whole groups of four digits.
    bdg_front #(
        .VALUE_BITS (VALUE_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data),
        .push      (push),
        .value     (value),
        .full      (full),
        .q_stat    (q_stat),
        .q_write   (q_write),
        .q_wdata   (q_wdata)
    );

    // The queue lets the front end keep taking words while the converter works.
    bdg_queue #(
        .WIDTH (QW),
        .DEPTH (bdg_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .wr_en (q_write),
        .wdata (q_wdata),
        .rd_en (q_read),
        .rdata (q_rdata),
        .stat  (q_stat)
    );

    // The back end converts to base 10000 and presents the groups most
    // significant first, with the run's sign, weight and count on each word.
    bdg_back #(
        .VALUE_BITS (VALUE_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_stat    (q_stat),
        .q_rdata   (q_rdata),
        .q_read    (q_read),
        .pop       (pop),
        .res_valid (res_valid),
        .res       (res)
    );

    assign empty       = !res_valid;
    assign digit_group = res.digit_group;
    assign negative    = res.negative;
    assign weight      = res.weight;
    assign group_count = res.group_count;
    assign group_index = res.group_index;
    assign last        = res.last;
    assign empty_res   = res.empty_res;

    // An empty run is a single word with weight -1 and no groups.
    `ASSERT_IMPLY(a_empty_run, clk, rst_n, !empty && res.empty_res, res.last && (res.group_count == 3'd0) && (res.weight == -4'sd1))
    // A group index always lies inside its run.
    `ASSERT_IMPLY(a_index_in_run, clk, rst_n, !empty && !res.empty_res, res.group_index < res.group_count)
    // The final word of a run carries the highest index.
    `ASSERT_IMPLY(a_last_index, clk, rst_n, !empty && !res.empty_res && res.last, res.group_index == res.group_count - 3'd1)
    // The conversion loop never leaves a group at or above the base.
    `ASSERT_IMPLY(a_group_range, clk, rst_n, !empty, res.digit_group < bdg_pkg::GROUP_W'(bdg_pkg::GROUP_BASE))

endmodule

// ===== sim/bdg_result_checker.sv =====
// Result checker for the base-10000 digit group converter: predicts the digit groups
// of each accepted word and compares them with the words leaving the result side.
// Depends on bdg_pkg for the result record and field widths.
module bdg_result_checker #(
    parameter int VALUE_BITS = 64
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write,
    input  logic [bdg_pkg::SCALE_W-1:0]      cfg_data,
    input  logic                             push,
    input  logic                             full,
    input  logic signed [VALUE_BITS-1:0]     value,
    input  logic                             pop,
    input  logic                             empty,
    input  logic [bdg_pkg::GROUP_W-1:0]      digit_group,
    input  logic                             negative,
    input  logic signed [3:0]                weight,
    input  logic [2:0]                       group_count,
    input  logic [2:0]                       group_index,
    input  logic                             last,
    input  logic                             empty_res,
    output int                               errors,
    output int                               outstanding
);

    bdg_pkg::res_t expected_groups[$];
    int unsigned   scale_copy = 0;
    int            fail_count = 0;

    function automatic logic [63:0] ten_to(input int unsigned e);
        logic [63:0] p;
        p = 64'd1;
        repeat (e) p = p * 64'd10;
        return p;
    endfunction

    // Splits one word into its integer and left-aligned fraction groups.
    function automatic void predict_groups(input logic [63:0] raw, input int unsigned scl);
        logic [63:0] mask;
        logic [63:0] mag;
        logic [63:0] ip;
        logic [63:0] fp;
        logic [63:0] g;
        logic        neg;
        logic [bdg_pkg::GROUP_W-1:0] int_grp [5];
        logic [bdg_pkg::GROUP_W-1:0] grp [6];
        int          n_int;
        int          n_frac;
        int          n;
        int          corr;
        int          k;
        int          i;
        bdg_pkg::res_t r;
        mask = (VALUE_BITS >= 64) ? {64{1'b1}} : ((64'd1 << VALUE_BITS) - 64'd1);
        raw  = raw & mask;
        neg  = raw[VALUE_BITS-1];
        mag  = neg ? ((~raw + 64'd1) & mask) : raw;
        if (scl > bdg_pkg::MAX_SCALE)
            scl = bdg_pkg::MAX_SCALE;
        ip = mag / ten_to(scl);
        fp = mag % ten_to(scl);
        n_int = 0;
        while (ip != 0 && n_int < 5)
        begin
            g = ip % 64'(bdg_pkg::GROUP_BASE);
            int_grp[n_int] = g[bdg_pkg::GROUP_W-1:0];
            ip = ip / 64'(bdg_pkg::GROUP_BASE);
            n_int++;
        end
        n = 0;
        for (i = n_int - 1; i >= 0; i--)
        begin
            grp[n] = int_grp[i];
            n++;
        end
        n_frac = (scl + 3) / 4;
        corr   = n_frac * 4 - scl;
        for (i = 0; i < n_frac; i++)
        begin
            k = n_frac - 1 - i;
            if (4 * k >= corr)
                g = (fp / ten_to(4 * k - corr)) % 64'(bdg_pkg::GROUP_BASE);
            else
                g = ((fp % 64'(bdg_pkg::GROUP_BASE)) * ten_to(corr))
                    % 64'(bdg_pkg::GROUP_BASE);
            grp[n] = g[bdg_pkg::GROUP_W-1:0];
            n++;
        end
        if (n == 0)
        begin
            r.digit_group = '0;
            r.negative    = neg;
            r.weight      = -4'sd1;
            r.group_count = 3'd0;
            r.group_index = 3'd0;
            r.last        = 1'b1;
            r.empty_res   = 1'b1;
            expected_groups.push_back(r);
        end
        else
        begin
            for (i = 0; i < n; i++)
            begin
                r.digit_group = grp[i];
                r.negative    = neg;
                r.weight      = 4'(n_int - 1);
                r.group_count = 3'(n);
                r.group_index = 3'(i);
                r.last        = (i == n - 1);
                r.empty_res   = 1'b0;
                expected_groups.push_back(r);
            end
        end
    endfunction

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        bdg_pkg::res_t want;
        if (!rst_n)
        begin
            scale_copy = 0;
            expected_groups.delete();
        end
        else
        begin
            if (pop && !empty)
            begin
                if (expected_groups.size() == 0)
                begin
                    $display("%0t: result word with no expectation waiting, expected none, actual %0d",
                             $time, digit_group);
                    fail_count++;
                end
                else
                begin
                    want = expected_groups.pop_front();
                    check_field("digit_group", want.digit_group, digit_group);
                    check_field("negative", want.negative, negative);
                    check_field("weight", $signed(want.weight), $signed(weight));
                    check_field("group_count", want.group_count, group_count);
                    check_field("group_index", want.group_index, group_index);
                    check_field("last", want.last, last);
                    check_field("empty_res", want.empty_res, empty_res);
                end
            end
            if (cfg_write)
                scale_copy = cfg_data;
            if (push && !full)
                predict_groups(64'(value), scale_copy);
        end
        errors      <= fail_count;
        outstanding <= expected_groups.size();
    end

endmodule

// ===== sim/tb.sv =====
// Top of the digit group converter testbench: clock, reset, stimulus and the verdict.
// Depends on bdg_pkg, the converter top level and bdg_result_checker.
module tb;

    localparam int VALUE_BITS   = 64;
    // Cycles the result side holds off during the pressure phase.
    localparam int STALL_CYCLES = 300;

    logic                         clk;
    logic                         rst_n;
    logic                         cfg_write;
    logic [bdg_pkg::SCALE_W-1:0]  cfg_data;
    logic                         push;
    logic signed [VALUE_BITS-1:0] value;
    logic                         full;
    logic                         empty;
    logic                         pop;
    logic [bdg_pkg::GROUP_W-1:0]  digit_group;
    logic                         negative;
    logic signed [3:0]            weight;
    logic [2:0]                   group_count;
    logic [2:0]                   group_index;
    logic                         last;
    logic                         empty_res;
    int                           errors;
    int                           outstanding;

    // Handshake between the stimulus process and the receiver process.
    bit stall_req = 0;   // ask the receiver for one long hold-off
    bit rx_steady = 0;   // receiver pops every cycle
    bit tx_steady = 0;   // sender offers a word every cycle

    binary_decimal_to_base10000_groups #(.VALUE_BITS(VALUE_BITS)) DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_data    (cfg_data),
        .push        (push),
        .value       (value),
        .full        (full),
        .empty       (empty),
        .pop         (pop),
        .digit_group (digit_group),
        .negative    (negative),
        .weight      (weight),
        .group_count (group_count),
        .group_index (group_index),
        .last        (last),
        .empty_res   (empty_res)
    );

    bdg_result_checker #(.VALUE_BITS(VALUE_BITS)) u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_data    (cfg_data),
        .push        (push),
        .full        (full),
        .value       (value),
        .pop         (pop),
        .empty       (empty),
        .digit_group (digit_group),
        .negative    (negative),
        .weight      (weight),
        .group_count (group_count),
        .group_index (group_index),
        .last        (last),
        .empty_res   (empty_res),
        .errors      (errors),
        .outstanding (outstanding)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Most gaps are none or short; a small share is long so that the idle
    // cycles land on every step of the conversion loop.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Random word with a bias toward interesting magnitudes: zero, the two extremes,
    // values of every length with either sign, and words sitting right at a
    // multiple of the current 10^scale split point or one away from it.
    function automatic logic [63:0] rand_word(input int unsigned scl);
        logic [63:0] r;
        logic [63:0] p;
        r = {$urandom, $urandom};
        p = 64'd1;
        case ($urandom_range(0, 11))
            0: r = 64'd0;
            1: r = 64'h7FFF_FFFF_FFFF_FFFF;
            2: r = 64'h8000_0000_0000_0000;
            3, 4: r = r >> $urandom_range(0, 63);
            5, 6: r = -(r >> $urandom_range(0, 63));
            7:
            begin
                repeat ((scl > bdg_pkg::MAX_SCALE) ? bdg_pkg::MAX_SCALE : scl) p = p * 64'd10;
                r = p * 64'($urandom_range(0, 60)) + 64'($urandom_range(0, 2)) - 64'd1;
                if ($urandom_range(0, 1))
                    r = -r;
            end
            default: ;
        endcase
        return r;
    endfunction

    // Offers one word and returns at the edge where it is accepted. A random
    // gap may follow; with no gap, push stays high for the next word.
    task automatic send_word(input logic [63:0] v);
        int gap;
        push  <= 1'b1;
        value <= v;
        @(posedge clk);
        while (full)
            @(posedge clk);
        gap = tx_steady ? 0 : pick_gap();
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Every word yields at least one result, so once the checker holds no
    // expectation the converter has nothing left in flight.
    task automatic wait_idle();
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    task automatic write_scale(input logic [bdg_pkg::SCALE_W-1:0] s);
        cfg_data  <= s;
        cfg_write <= 1'b1;
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    // Ends a batch of words: lowers push and drains the converter so that
    // the scale register can be rewritten safely.
    task automatic close_batch();
        push <= 1'b0;
        wait_idle();
    endtask

    // Stimulus. The directed words come first, beginning under the scale that
    // reset leaves behind; random batches follow, each under its own scale.
    initial
    begin
        int unsigned scl;
        int          count;
        clk       = 1'b0;
        rst_n     = 1'b0;
        cfg_write = 1'b0;
        cfg_data  = '0;
        push      = 1'b0;
        value     = '0;
        pop       = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Scale zero from reset: zero is the empty case, the rest are pure
        // integers including both extremes and a group boundary.
        send_word(64'd0);
        send_word(64'd1);
        send_word(-64'd1);
        send_word(64'd9999);
        send_word(64'd10000);
        send_word(64'h7FFF_FFFF_FFFF_FFFF);
        send_word(64'h8000_0000_0000_0000);
        close_batch();

        // Widest fraction: five fraction groups, zero no longer empty.
        write_scale(5'd18);
        send_word(64'd0);
        send_word(64'h7FFF_FFFF_FFFF_FFFF);
        send_word(64'h8000_0000_0000_0000);
        send_word(64'd1);
        send_word(-64'd1);
        close_batch();

        // Scale above range must behave as the widest legal scale.
        write_scale(5'd31);
        send_word(64'd123456789);
        send_word(-64'd5);
        close_batch();

        // Fraction narrower than one group, left aligned.
        write_scale(5'd3);
        send_word(64'd0);
        send_word(64'd999);
        send_word(64'd1000);
        send_word(-64'd1001);
        close_batch();

        // Fraction just over one group.
        write_scale(5'd5);
        send_word(64'd99999);
        send_word(64'd100000);
        close_batch();

        // Random batches. Batch 1 runs with no idling on either side; batch 3
        // is the pressure batch, where the receiver stops for a long stretch
        // while the sender keeps offering words.
        for (int ph = 0; ph < 12; ph++)
        begin
            case (ph)
                0: scl = 18;
                1: scl = 0;
                2: scl = 31;
                default: scl = ($urandom_range(0, 7) == 0) ? 31 : $urandom_range(0, 20);
            endcase
            write_scale(bdg_pkg::SCALE_W'(scl));
            count     = (ph == 3) ? 60 : 30;
            tx_steady = (ph == 1) || (ph == 3) || ($urandom_range(0, 3) == 0);
            rx_steady = (ph == 1) || ($urandom_range(0, 3) == 0);
            if (ph == 3)
                stall_req = 1;
            for (int i = 0; i < count; i++)
                send_word(rand_word(scl));
            close_batch();
        end

        repeat (40) @(posedge clk);
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Receiver. Pops with random gaps unless told to run steady, and takes one
    // long hold-off when the stimulus asks for it.
    initial
    begin
        int g;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (stall_req)
            begin
                stall_req = 0;
                pop <= 1'b0;
                repeat (STALL_CYCLES) @(posedge clk);
            end
            else if (rx_steady)
            begin
                pop <= 1'b1;
                @(posedge clk);
            end
            else
            begin
                g = pick_gap();
                pop <= (g == 0);
                repeat ((g == 0) ? 1 : g) @(posedge clk);
            end
        end
    end

    // Hard stop far beyond the slowest correct run.
    initial
    begin
        #3000000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+design
design/bdg_pkg.sv
design/bdg_front.sv
design/bdg_queue.sv
design/bdg_back.sv
design/binary_decimal_to_base10000_groups.sv
sim/bdg_result_checker.sv
sim/tb.sv
